/* rtl/iorrob_pkg.sv */
package iorrob_pkg;

    localparam int ID_W = 32;
    localparam int DATA_W = 64;
    localparam int RESULT_LIMIT = 32;
    localparam int CNT_W = $clog2(RESULT_LIMIT + 1);

    localparam logic STATUS_RELEASED = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic calc;
        logic store;
        logic head_rd;
        logic take;
        logic emit_pend;
        logic emit_last;
        logic emit_rej;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_of_window;
        logic rd_valid;
        logic limit_hit;
        logic pend_valid;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/iorrob_ctrl.sv */
module iorrob_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  iorrob_pkg::dp_stat_t   st,
    output iorrob_pkg::ctrl_cmd_t  cmd
);
    import iorrob_pkg::*;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_CALC    = 3'd2;
    localparam logic [2:0] S_CHECK   = 3'd3;
    localparam logic [2:0] S_REJ     = 3'd4;
    localparam logic [2:0] S_HEAD_RD = 3'd5;
    localparam logic [2:0] S_REL     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (st.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                if (st.out_of_window) begin
                    state_next = S_REJ;
                end else begin
                    cmd.calc = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (st.rd_valid) begin
                    state_next = S_REJ;
                end else begin
                    cmd.store = 1'b1;
                    state_next = S_HEAD_RD;
                end
            end
            S_REJ: begin
                if (st.out_free) begin
                    cmd.emit_rej = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_HEAD_RD: begin
                cmd.head_rd = 1'b1;
                state_next = S_REL;
            end
            S_REL: begin
                if (st.rd_valid && !st.limit_hit) begin
                    if (!st.pend_valid || st.out_free) begin
                        cmd.emit_pend = st.pend_valid;
                        cmd.take = 1'b1;
                        state_next = S_HEAD_RD;
                    end
                end else if (!st.pend_valid) begin
                    state_next = S_IDLE;
                end else if (st.out_free) begin
                    cmd.emit_pend = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/iorrob_dp.sv */
module iorrob_dp #(
    parameter int DEPTH = 32,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [iorrob_pkg::ID_W-1:0]        s_seq_id,
    input  logic [iorrob_pkg::DATA_W-1:0]      s_payload,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_status,
    output logic [iorrob_pkg::ID_W-1:0]        m_out_id,
    output logic [iorrob_pkg::DATA_W-1:0]      m_out_payload,
    output logic                               m_last,
    input  iorrob_pkg::ctrl_cmd_t              cmd,
    output iorrob_pkg::dp_stat_t               st
);
    import iorrob_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                     valid_mem [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] payload_mem [DEPTH];

    logic [AW-1:0]            clr_idx_reg;
    logic [AW-1:0]            head_reg;
    logic [ID_W-1:0]          next_exp_reg;
    logic [ID_W-1:0]          seq_reg;
    logic [ID_W-1:0]          offset_reg;
    logic [PAYLOAD_WIDTH-1:0] data_reg;
    logic [AW-1:0]            slot_reg;
    logic                     rd_valid_reg;
    logic [PAYLOAD_WIDTH-1:0] rd_payload_reg;
    logic [CNT_W-1:0]         n_reg;
    logic                     pend_valid_reg;
    logic [ID_W-1:0]          pend_id_reg;
    logic [PAYLOAD_WIDTH-1:0] pend_payload_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     out_status_reg;
    logic [ID_W-1:0]          out_id_reg;
    logic [DATA_W-1:0]        out_payload_reg;
    logic                     out_last_reg;

    logic [AW:0]              slot_sum;
    logic [AW-1:0]            slot_calc;
    logic [AW-1:0]            head_inc;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic                     wr_bit;
    logic [DATA_W-1:0]        pend_ext;

    always_comb begin
        slot_sum = {1'b0, head_reg} + {1'b0, offset_reg[AW-1:0]};
        if (slot_sum >= (AW + 1)'(DEPTH)) begin
            slot_calc = AW'(slot_sum - (AW + 1)'(DEPTH));
        end else begin
            slot_calc = slot_sum[AW-1:0];
        end
        if (head_reg == AW'(DEPTH - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = head_reg + 1'b1;
        end
        rd_addr = cmd.calc ? slot_calc : head_reg;
        wr_en   = cmd.clr_wr || cmd.store || cmd.take;
        wr_bit  = cmd.store;
        if (cmd.clr_wr) begin
            wr_addr = clr_idx_reg;
        end else if (cmd.store) begin
            wr_addr = slot_reg;
        end else begin
            wr_addr = head_reg;
        end
        pend_ext = '0;
        pend_ext[PAYLOAD_WIDTH-1:0] = pend_payload_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            valid_mem[wr_addr] <= wr_bit;
        end
        if (cmd.calc || cmd.head_rd) begin
            rd_valid_reg <= valid_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            payload_mem[slot_reg] <= data_reg;
        end
        if (cmd.head_rd) begin
            rd_payload_reg <= payload_mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            seq_reg    <= s_seq_id;
            offset_reg <= s_seq_id - next_exp_reg;
            data_reg   <= s_payload[PAYLOAD_WIDTH-1:0];
        end
        if (cmd.calc) begin
            slot_reg <= slot_calc;
        end
        if (cmd.take) begin
            pend_id_reg      <= next_exp_reg;
            pend_payload_reg <= rd_payload_reg;
        end
        if (cmd.emit_rej) begin
            out_status_reg  <= STATUS_REJECTED;
            out_id_reg      <= seq_reg;
            out_payload_reg <= '0;
            out_last_reg    <= 1'b1;
        end else if (cmd.emit_pend) begin
            out_status_reg  <= STATUS_RELEASED;
            out_id_reg      <= pend_id_reg;
            out_payload_reg <= pend_ext;
            out_last_reg    <= cmd.emit_last;
        end
    end

    always_comb begin
        if (cmd.emit_rej || cmd.emit_pend) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg    <= '0;
            head_reg       <= '0;
            next_exp_reg   <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cmd.clr_wr) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.accept) begin
                n_reg <= '0;
            end else if (cmd.take) begin
                n_reg <= n_reg + 1'b1;
            end
            if (cmd.take) begin
                head_reg       <= head_inc;
                next_exp_reg   <= next_exp_reg + 1'b1;
                pend_valid_reg <= 1'b1;
            end else if (cmd.emit_pend) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        st.clr_last      = (clr_idx_reg == AW'(DEPTH - 1));
        st.out_of_window = (offset_reg >= ID_W'(DEPTH));
        st.rd_valid      = rd_valid_reg;
        st.limit_hit     = (n_reg == CNT_W'(RESULT_LIMIT));
        st.pend_valid    = pend_valid_reg;
        st.out_free      = !out_valid_reg || m_ready;
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_out_id      = out_id_reg;
    assign m_out_payload = out_payload_reg;
    assign m_last        = out_last_reg;

endmodule

/* rtl/in_order_release_reorder_buffer_top.sv */
// Reorder buffer that takes items tagged with a 32-bit sequence number in any order and
// releases their payloads strictly in sequence order, starting from sequence number zero
// after reset. Items are held in a window of DEPTH slots beginning at the next expected
// number; an item outside that window, or one whose number is already pending, produces a
// single rejected item and is not stored. Every accepted item that completes a run releases
// that run, at most 32 items, and the final item it causes has m_last set; an item that is
// stored but not at the head produces nothing. After reset the block clears its whole slot
// valid memory before s_ready rises. One item is handled at a time: an item outside the
// window is checked and rejected, a duplicate is also looked up in its slot before it is
// rejected, and a stored item is written and then each item it releases takes a head read
// and a release step, since the slot memories have a single read port and registered read
// data. Stalls on m_ready hold the rejection and release steps.
module in_order_release_reorder_buffer_top #(
    parameter int DEPTH = 32,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [iorrob_pkg::ID_W-1:0]        s_seq_id,
    input  logic [iorrob_pkg::DATA_W-1:0]      s_payload,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_status,
    output logic [iorrob_pkg::ID_W-1:0]        m_out_id,
    output logic [iorrob_pkg::DATA_W-1:0]      m_out_payload,
    output logic                               m_last
);
    import iorrob_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  st;

    iorrob_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    iorrob_dp #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_seq_id      (s_seq_id),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_id      (m_out_id),
        .m_out_payload (m_out_payload),
        .m_last        (m_last),
        .cmd           (cmd),
        .st            (st)
    );

    a_rej_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_REJECTED) |-> m_last)
        else $error("rejected item without last flag");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in progress");

    a_store_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> (!st.rd_valid && !st.out_of_window))
        else $error("store into a pending or out of window slot");

    a_take_valid_head: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> (st.rd_valid && !st.limit_hit))
        else $error("release of an empty head slot or beyond the run limit");

endmodule
